FILE: design/assert_macros.svh
// Assertion macros for the peer record table RTL.
// Included by modules that check their own sequencing; empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/prt_pkg.sv
// Package for the peer record table: command codes, record layout and constants.
// Used by peer_record_table_top and its testbench; depends on nothing.
`default_nettype none
package prt_pkg;
  localparam int TABLE_SLOTS_DEF = 64;
  localparam logic [6:0] LIMIT_RESET = 7'd64;

  localparam logic [2:0] CMD_INSERT    = 3'd0;
  localparam logic [2:0] CMD_GET_RTT   = 3'd1;
  localparam logic [2:0] CMD_GET_ID    = 3'd2;
  localparam logic [2:0] CMD_CLEAR_RTT = 3'd3;
  localparam logic [2:0] CMD_FLOW      = 3'd4;

  localparam logic [16:0] DELAY_LONG  = 17'd100000;
  localparam logic [16:0] DELAY_SHORT = 17'd10000;
  localparam logic signed [49:0] MS_US = 50'sd1000;
  localparam logic signed [49:0] TH_LONG = 50'sd100;
  localparam logic signed [49:0] TH_SHORT = 50'sd10;

  typedef struct packed {
    logic [31:0]        addr;
    logic [15:0]        port;
    logic [31:0]        session;
    logic signed [31:0] id;
    logic signed [24:0] rtt;
    logic [47:0]        stamp;
    logic [23:0]        window;
  } rec_t;
endpackage
`default_nettype wire

FILE: design/peer_record_table_top.sv
// Peer record table: every command code up to CMD_FLOW scans all TABLE_SLOTS
// slots of one record memory (one slot per cycle, read data registered), and an
// insert then passes through S_INS to write; an insert whose new count exceeds
// record_limit scans the memory a second time to find and drop the oldest record.
// Flow control adds the S_FLOW1 and S_FLOW2 states. Valid bits are flip-flops
// cleared by reset, so no clearing pass is needed. Depends on prt_pkg and
// assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module peer_record_table_top
  import prt_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [6:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         cmd,
  input  wire logic [31:0]        peer_addr,
  input  wire logic [15:0]        peer_port,
  input  wire logic [31:0]        session_num,
  input  wire logic [30:0]        new_id,
  input  wire logic [23:0]        new_rtt,
  input  wire logic [23:0]        flow_window,
  input  wire logic [47:0]        now_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    found,
  output logic signed [24:0]      rtt_out,
  output logic signed [31:0]      id_out,
  output logic [16:0]             delay_us
);
  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int PTR_W = $clog2(TABLE_SLOTS + 1);
  localparam int CMP_W = (PTR_W > 7) ? PTR_W : 7;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_INS, S_EVSCAN, S_FLOW1, S_FLOW2, S_DONE
  } state_t;

  state_t state;
  rec_t mem [TABLE_SLOTS];
  rec_t rdata, mem_wd, hit_rec, upd_rec, new_rec;
  logic mem_we;
  logic [IDX_W-1:0] mem_wa, rd_idx, hit_idx, free_idx, old_idx, place_idx;
  logic [TABLE_SLOTS-1:0] valid;
  logic [PTR_W-1:0] ptr, cnt, cnt_new;
  logic [6:0] record_limit;
  logic rd_pend, issuing, scan_end;
  logic hit, free_ok, old_ok, rtt_ok, place_ok;
  logic [47:0] old_stamp;
  logic signed [24:0] rtt_val;
  logic [2:0] c_cmd;
  logic [31:0] c_addr, c_session;
  logic [15:0] c_port;
  logic [30:0] c_id;
  logic [23:0] c_rtt, c_window;
  logic [47:0] c_now;
  logic v_cur, addr_hit, key_hit, older;
  logic [27:0] fold;
  logic signed [49:0] el, pa1, pb1, pa2, pb2, w_ext;
  logic c_long, c_short;
  logic r_found;
  logic signed [24:0] r_rtt;
  logic signed [31:0] r_id;
  logic [16:0] r_delay;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign issuing   = (ptr < PTR_W'(TABLE_SLOTS));
  assign scan_end  = !issuing && !rd_pend;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[ptr[IDX_W-1:0]];
  end

  always_comb begin
    v_cur    = valid[rd_idx];
    addr_hit = v_cur && (rdata.addr == c_addr);
    key_hit  = addr_hit && (rdata.port == c_port) && (rdata.session == c_session);
    older    = v_cur && (!old_ok || (rdata.stamp < old_stamp));
    fold = ({3'b0, hit_rec.rtt} << 3) - {3'b0, hit_rec.rtt} + {4'b0, c_rtt};
    upd_rec = hit_rec;
    if (c_id != 31'd0) begin
      upd_rec.id = {1'b0, c_id};
    end
    if (c_rtt != 24'd0) begin
      upd_rec.rtt = (hit_rec.rtt == -25'sd1) ? {1'b0, c_rtt} : fold[27:3];
    end
    upd_rec.stamp  = c_now;
    upd_rec.window = c_window;
    new_rec.addr    = c_addr;
    new_rec.port    = c_port;
    new_rec.session = c_session;
    new_rec.id      = (c_id != 31'd0) ? {1'b0, c_id} : -32'sd1;
    new_rec.rtt     = (c_rtt != 24'd0) ? {1'b0, c_rtt} : -25'sd1;
    new_rec.stamp   = c_now;
    new_rec.window  = c_window;
    place_ok  = free_ok || (old_ok && (c_now >= old_stamp));
    place_idx = free_ok ? free_idx : old_idx;
    cnt_new   = free_ok ? cnt + PTR_W'(1) : cnt;
    mem_we = 1'b0;
    mem_wa = rd_idx;
    mem_wd = rdata;
    if (state == S_SCAN && rd_pend && c_cmd == CMD_CLEAR_RTT && addr_hit) begin
      mem_we = 1'b1;
      mem_wd.rtt = -25'sd1;
    end else if (state == S_INS) begin
      if (hit) begin
        mem_we = 1'b1;
        mem_wa = hit_idx;
        mem_wd = upd_rec;
      end else if (place_ok) begin
        mem_we = 1'b1;
        mem_wa = place_idx;
        mem_wd = new_rec;
      end
    end
    w_ext = {26'b0, hit_rec.window};
    c_long  = (el >= 0) ? (el < pa1) : (el <= pb1);
    c_short = (el >= 0) ? (el < pa2) : (el <= pb2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid        <= '0;
      out_valid    <= 1'b0;
      rd_pend      <= 1'b0;
      ptr          <= '0;
      record_limit <= LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        record_limit <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_pend <= 1'b0;
      if (state == S_SCAN || state == S_EVSCAN) begin
        rd_idx  <= ptr[IDX_W-1:0];
        rd_pend <= issuing;
        if (issuing) begin
          ptr <= ptr + PTR_W'(1);
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            c_cmd <= cmd; c_addr <= peer_addr; c_port <= peer_port;
            c_session <= session_num; c_id <= new_id; c_rtt <= new_rtt;
            c_window <= flow_window; c_now <= now_time;
            hit <= 1'b0; free_ok <= 1'b0; old_ok <= 1'b0; rtt_ok <= 1'b0;
            cnt <= '0; ptr <= '0;
            r_found <= 1'b0; r_rtt <= '0; r_id <= '0; r_delay <= '0;
            state <= (cmd > CMD_FLOW) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_pend) begin
            if (key_hit && !hit) begin
              hit <= 1'b1; hit_idx <= rd_idx; hit_rec <= rdata;
            end
            if (c_cmd == CMD_GET_RTT || c_cmd == CMD_CLEAR_RTT) begin
              if (addr_hit) begin
                hit <= 1'b1;
                if (rdata.rtt > 0 && !rtt_ok) begin
                  rtt_ok <= 1'b1; rtt_val <= rdata.rtt;
                end
              end
            end
            if (!v_cur && !free_ok) begin
              free_ok <= 1'b1; free_idx <= rd_idx;
            end
            if (v_cur) begin
              cnt <= cnt + PTR_W'(1);
            end
            if (older) begin
              old_ok <= 1'b1; old_idx <= rd_idx; old_stamp <= rdata.stamp;
            end
          end
          if (scan_end) begin
            r_found <= hit;
            state <= S_DONE;
            case (c_cmd)
              CMD_INSERT: state <= S_INS;
              CMD_GET_RTT: r_rtt <= rtt_ok ? rtt_val : -25'sd1;
              CMD_GET_ID: r_id <= hit ? hit_rec.id : -32'sd1;
              CMD_FLOW: if (hit) state <= S_FLOW1;
              default: ;
            endcase
          end
        end
        S_INS: begin
          state <= S_DONE;
          if (!hit && place_ok) begin
            valid[place_idx] <= 1'b1;
            if (CMP_W'(cnt_new) > CMP_W'(record_limit)) begin
              ptr <= '0; old_ok <= 1'b0;
              state <= S_EVSCAN;
            end
          end
        end
        S_EVSCAN: begin
          if (rd_pend && older) begin
            old_ok <= 1'b1; old_idx <= rd_idx; old_stamp <= rdata.stamp;
          end
          if (scan_end) begin
            if (old_ok) begin
              valid[old_idx] <= 1'b0;
            end
            state <= S_DONE;
          end
        end
        S_FLOW1: begin
          el  <= $signed({2'b0, c_now}) - $signed({2'b0, hit_rec.stamp});
          pa1 <= (w_ext - TH_LONG) * MS_US;
          pb1 <= (w_ext - TH_LONG - 50'sd1) * MS_US;
          pa2 <= (w_ext - TH_SHORT) * MS_US;
          pb2 <= (w_ext - TH_SHORT - 50'sd1) * MS_US;
          state <= S_FLOW2;
        end
        S_FLOW2: begin
          r_delay <= c_long ? DELAY_LONG : (c_short ? DELAY_SHORT : 17'd0);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            found <= r_found; rtt_out <= r_rtt; id_out <= r_id; delay_us <= r_delay;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_write_phase, clk, rst, mem_we, state == S_SCAN || state == S_INS)
  `ASSERT_IMPL(a_delay_found, clk, rst, out_valid && delay_us != 17'd0, found)
  `ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, state != S_IDLE)
endmodule
`default_nettype wire

FILE: test/peer_record_table_top_tb.sv
// Self-checking testbench for peer_record_table_top: random and directed
// table commands against a behavioral predictor held in a scoreboard class.
// Depends on prt_pkg and the peer_record_table_top RTL.
`default_nettype none
module peer_record_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prt_pkg::*;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 1200000;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] session;
    logic [30:0] id;
    logic [23:0] rtt;
    logic [23:0] window;
    logic [47:0] now;
  } request_t;

  typedef struct {
    logic               found;
    logic signed [24:0] rtt;
    logic signed [31:0] id;
    logic [16:0]        delay;
  } answer_t;

  class peer_table_board;
    bit                 valid [SLOTS];
    logic [31:0]        addr [SLOTS];
    logic [15:0]        port [SLOTS];
    logic [31:0]        session [SLOTS];
    logic signed [31:0] id [SLOTS];
    logic signed [24:0] rtt [SLOTS];
    logic [47:0]        stamp [SLOTS];
    logic [23:0]        window [SLOTS];
    int unsigned        limit;
    answer_t            pending [$];
    int                 errors;
    int                 checked;

    function new();
      foreach (valid[k]) valid[k] = 0;
      limit = LIMIT_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function int find_key(logic [31:0] a, logic [15:0] p, logic [31:0] s);
      for (int k = 0; k < SLOTS; k++)
        if (valid[k] && addr[k] == a && port[k] == p && session[k] == s) return k;
      return -1;
    endfunction

    function int find_oldest();
      int best;
      best = -1;
      for (int k = 0; k < SLOTS; k++)
        if (valid[k] && (best < 0 || stamp[k] < stamp[best])) best = k;
      return best;
    endfunction

    function void insert(request_t r, ref answer_t ans);
      int k;
      int cnt;
      int j;
      logic [31:0] mix;
      k = find_key(r.addr, r.port, r.session);
      cnt = 0;
      if (k >= 0) begin
        ans.found = 1;
        if (r.id != 0) id[k] = {1'b0, r.id};
        if (r.rtt != 0) begin
          if (rtt[k] == -1) begin
            rtt[k] = {1'b0, r.rtt};
          end else begin
            mix = (32'(rtt[k]) * 7 + 32'(r.rtt)) >> 3;
            rtt[k] = mix[24:0];
          end
        end
        stamp[k] = r.now;
        window[k] = r.window;
        return;
      end
      for (j = 0; j < SLOTS; j++)
        if (!valid[j]) begin
          if (k < 0) k = j;
        end else begin
          cnt++;
        end
      if (k < 0) begin
        k = find_oldest();
        if (k < 0 || r.now < stamp[k]) return;
        cnt--;
      end
      valid[k] = 1;
      addr[k] = r.addr;
      port[k] = r.port;
      session[k] = r.session;
      id[k] = (r.id != 0) ? {1'b0, r.id} : -32'sd1;
      rtt[k] = (r.rtt != 0) ? {1'b0, r.rtt} : -25'sd1;
      stamp[k] = r.now;
      window[k] = r.window;
      cnt++;
      if (cnt > limit) begin
        j = find_oldest();
        if (j >= 0) valid[j] = 0;
      end
    endfunction

    function void note_request(request_t r);
      answer_t ans;
      int k;
      longint elapsed;
      longint thresh;
      ans = '{found: 0, rtt: 0, id: 0, delay: 0};
      case (r.cmd)
        CMD_INSERT: insert(r, ans);
        CMD_GET_RTT: begin
          ans.rtt = -1;
          for (k = 0; k < SLOTS; k++)
            if (valid[k] && addr[k] == r.addr) begin
              ans.found = 1;
              if (rtt[k] > 0) begin
                ans.rtt = rtt[k];
                break;
              end
            end
        end
        CMD_GET_ID: begin
          ans.id = -1;
          k = find_key(r.addr, r.port, r.session);
          if (k >= 0) begin
            ans.found = 1;
            ans.id = id[k];
          end
        end
        CMD_CLEAR_RTT: begin
          for (k = 0; k < SLOTS; k++)
            if (valid[k] && addr[k] == r.addr) begin
              ans.found = 1;
              rtt[k] = -1;
            end
        end
        CMD_FLOW: begin
          k = find_key(r.addr, r.port, r.session);
          if (k >= 0) begin
            elapsed = longint'({16'd0, r.now}) - longint'({16'd0, stamp[k]});
            thresh = longint'({40'd0, window[k]}) - elapsed / 1000;
            ans.found = 1;
            if (thresh > 100) ans.delay = DELAY_LONG;
            else if (thresh > 10) ans.delay = DELAY_SHORT;
          end
        end
        default: ;
      endcase
      pending.push_back(ans);
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result found=%0d rtt=%0d id=%0d delay=%0d",
                 $time, got.found, got.rtt, got.id, got.delay);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.found !== want.found) begin
        $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
        errors++;
      end
      if (got.rtt !== want.rtt) begin
        $display("%0t: rtt_out expected %0d actual %0d", $time, want.rtt, got.rtt);
        errors++;
      end
      if (got.id !== want.id) begin
        $display("%0t: id_out expected %0d actual %0d", $time, want.id, got.id);
        errors++;
      end
      if (got.delay !== want.delay) begin
        $display("%0t: delay_us expected %0d actual %0d", $time, want.delay, got.delay);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [6:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [2:0] cmd;
  logic [31:0] peer_addr;
  logic [15:0] peer_port;
  logic [31:0] session_num;
  logic [30:0] new_id;
  logic [23:0] new_rtt;
  logic [23:0] flow_window;
  logic [47:0] now_time;
  logic out_valid;
  logic out_ready;
  logic found;
  logic signed [24:0] rtt_out;
  logic signed [31:0] id_out;
  logic [16:0] delay_us;

  peer_record_table_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .peer_addr(peer_addr), .peer_port(peer_port),
    .session_num(session_num), .new_id(new_id), .new_rtt(new_rtt),
    .flow_window(flow_window), .now_time(now_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(found), .rtt_out(rtt_out), .id_out(id_out), .delay_us(delay_us)
  );

  peer_table_board board;
  bit quiet_phase;
  bit hold_receiver;
  int cycles;
  int sent;
  logic [31:0] addr_pool [8];
  logic [15:0] port_pool [4];
  logic [31:0] session_pool [4];
  logic [47:0] clock_us;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout at %0t", $time);
        $display("[peer_record_table_top] ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request, and result checking.
  initial begin
    int gap;
    answer_t got;
    out_ready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_receiver) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_receiver = 0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 8);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '{found: found, rtt: rtt_out, id: id_out, delay: delay_us};
        board.check_answer(got);
      end
    end
  end

  task automatic send_request(request_t r);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1;
    cmd <= r.cmd;
    peer_addr <= r.addr;
    peer_port <= r.port;
    session_num <= r.session;
    new_id <= r.id;
    new_rtt <= r.rtt;
    flow_window <= r.window;
    now_time <= r.now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(r);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 20) @(posedge clk);
  endtask

  task automatic write_limit(logic [6:0] value);
    cfg_valid <= 1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.limit = value;
    cfg_valid <= 0;
  endtask

  function automatic request_t make_request(logic [2:0] c, int a, int p, int s);
    request_t r;
    r.cmd = c;
    r.addr = addr_pool[a];
    r.port = port_pool[p];
    r.session = session_pool[s];
    r.id = ($urandom_range(0, 4) == 0) ? 31'd0 : 31'($urandom());
    r.rtt = ($urandom_range(0, 4) == 0) ? 24'd0 : 24'($urandom());
    r.window = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 300)) : 24'($urandom());
    r.now = clock_us;
    return r;
  endfunction

  task automatic random_phase(int count, int spread);
    request_t r;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: r = make_request(CMD_INSERT, $urandom_range(0, spread),
                                     $urandom_range(0, 3), $urandom_range(0, 3));
        4: r = make_request(CMD_GET_RTT, $urandom_range(0, 7), 0, 0);
        5: r = make_request(CMD_GET_ID, $urandom_range(0, spread),
                            $urandom_range(0, 3), $urandom_range(0, 3));
        6: r = make_request(CMD_CLEAR_RTT, $urandom_range(0, 7), 0, 0);
        7, 8: r = make_request(CMD_FLOW, $urandom_range(0, spread),
                               $urandom_range(0, 3), $urandom_range(0, 3));
        default: begin
          r = make_request(3'($urandom_range(5, 7)), 0, 0, 0);
          r.addr = $urandom();
          r.now = {$urandom(), 16'($urandom())};
        end
      endcase
      if ($urandom_range(0, 19) == 0) begin
        r.addr = $urandom();
        r.port = 16'($urandom());
        r.session = $urandom();
      end
      case ($urandom_range(0, 9))
        0: r.now = clock_us - 48'($urandom_range(0, 400000));
        1: r.now = {$urandom(), 16'($urandom())};
        default: begin
          clock_us = clock_us + 48'($urandom_range(0, 150000));
          r.now = clock_us;
        end
      endcase
      send_request(r);
    end
  endtask

  initial begin
    request_t r;
    board = new();
    rst = 1;
    cfg_valid = 0;
    cfg_data = 0;
    in_valid = 0;
    cmd = 0;
    peer_addr = 0;
    peer_port = 0;
    session_num = 0;
    new_id = 0;
    new_rtt = 0;
    flow_window = 0;
    now_time = 0;
    quiet_phase = 0;
    hold_receiver = 0;
    sent = 0;
    clock_us = 48'd5000000;
    addr_pool = '{32'h0, 32'hFFFFFFFF, 32'hC0A80001, 32'h0A000001,
                  32'h7F000001, 32'h80000000, 32'h55AA55AA, 32'h01020304};
    port_pool = '{16'h0, 16'hFFFF, 16'd8080, 16'd443};
    session_pool = '{32'h0, 32'hFFFFFFFF, 32'd1, 32'h12345678};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, each command, folding, clearing, unused codes.
    r = '{CMD_GET_RTT, 32'hFFFFFFFF, 16'h0, 32'h0, 31'd0, 24'd0, 24'd0, 48'd0};
    send_request(r);
    r = '{CMD_INSERT, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF,
          24'hFFFFFF, 24'hFFFFFF, 48'hFFFFFFFFFFFF};
    send_request(r);
    r.rtt = 24'd8; r.id = 31'd0; send_request(r);
    r.cmd = CMD_GET_ID; send_request(r);
    r.cmd = CMD_GET_RTT; send_request(r);
    r.cmd = CMD_FLOW; r.now = 48'd0; send_request(r);
    r = '{CMD_INSERT, 32'h0, 16'h0, 32'h0, 31'd0, 24'd0, 24'd50, 48'd1000};
    send_request(r);
    r.cmd = CMD_GET_RTT; send_request(r);
    r.cmd = CMD_GET_ID; send_request(r);
    r.cmd = CMD_INSERT; r.rtt = 24'd100; r.id = 31'd1; send_request(r);
    r.rtt = 24'd200; send_request(r);
    r.cmd = CMD_FLOW; r.now = 48'd35000; send_request(r);
    r.now = 48'd45000; send_request(r);
    r.now = 48'd1000000; send_request(r);
    r.cmd = CMD_CLEAR_RTT; send_request(r);
    r.cmd = CMD_GET_RTT; send_request(r);
    r.cmd = CMD_CLEAR_RTT; r.addr = 32'h5; send_request(r);
    r.cmd = 3'd5; send_request(r);
    r.cmd = 3'd6; r.addr = 32'hFFFFFFFF; send_request(r);
    r.cmd = 3'd7; r.now = 48'hFFFFFFFFFFFF; send_request(r);
    drain();

    // Full table with the reset limit of 64, then long receiver hold-off.
    random_phase(200, 7);
    for (int n = 0; n < 80; n++) begin
      r = make_request(CMD_INSERT, 0, 0, 0);
      r.addr = $urandom();
      clock_us = clock_us + 48'($urandom_range(0, 3));
      r.now = ($urandom_range(0, 7) == 0) ? 48'd0 : clock_us;
      send_request(r);
    end
    hold_receiver = 1;
    random_phase(60, 7);
    drain();

    write_limit(7'd1);
    random_phase(150, 3);
    drain();
    write_limit(7'd0);
    random_phase(80, 3);
    drain();
    write_limit(7'd127);
    random_phase(150, 7);
    drain();
    write_limit(7'd5);
    random_phase(200, 7);
    drain();
    write_limit(7'd64);
    quiet_phase = 1;
    random_phase(180, 7);
    drain();

    $display("Sent %0d requests over limits 64, 1, 0, 127, 5 and 64; %0d results checked.",
             sent, board.checked);
    if (board.errors == 0) begin
      $display("[peer_record_table_top] OK");
    end else begin
      $display("[peer_record_table_top] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
